@@ src/tgss_pkg.sv @@
// ----------------------------------------------------------------------------
// tgss_pkg
// Types, codes and gear tables shared by the gear shift sequencer files.
// ----------------------------------------------------------------------------
package tgss_pkg;

  // sequencer phases, values match the status code on the phase field
  typedef enum logic [3:0] {
    PH_INIT_CENTER   = 4'd0,
    PH_INIT_SETTLE   = 4'd1,
    PH_IDLE          = 4'd2,
    PH_MOVE_CHECK    = 4'd3,
    PH_CENTER        = 4'd4,
    PH_CENTER_SETTLE = 4'd5,
    PH_X_MOVE        = 4'd6,
    PH_X_RECOVER     = 4'd7,
    PH_X_SETTLE      = 4'd8,
    PH_Y_MOVE        = 4'd9,
    PH_Y_RECOVER     = 4'd10,
    PH_DONE_SETTLE   = 4'd11
  } phase_t;

  // axis position codes
  localparam logic [1:0] POS_LOW    = 2'd0;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam logic [1:0] POS_HIGH   = 2'd2;

  // gear codes
  localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
  localparam logic [2:0] GEAR_MAX     = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_X_TIMEOUT     = 3'd0;
  localparam logic [2:0] CFG_Y_TIMEOUT     = 3'd1;
  localparam logic [2:0] CFG_LONG_SETTLE   = 3'd2;
  localparam logic [2:0] CFG_CENTER_SETTLE = 3'd3;
  localparam logic [2:0] CFG_ATTEMPT_LIMIT = 3'd4;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  // input transaction
  typedef struct packed {
    logic       kind;
    logic [2:0] gear;
    logic [1:0] x_position;
    logic [1:0] y_position;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [1:0] x_drive_target;
    logic [1:0] y_drive_target;
    logic       x_enable;
    logic       y_enable;
    logic       ready_res;
    logic [2:0] current_gear;
    logic [3:0] phase;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] x_timeout_ticks;
    logic [15:0] y_timeout_ticks;
    logic [15:0] long_settle_ticks;
    logic [15:0] center_settle_ticks;
    logic [2:0]  attempt_limit;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    phase_t      phase_reg;
    logic [1:0]  goal_x;
    logic [1:0]  goal_y;
    logic [2:0]  selected_gear;
    logic [2:0]  attempts_left;
    logic [15:0] wait_timer;
    logic [1:0]  x_setpoint;
    logic [1:0]  y_setpoint;
    logic        x_on;
    logic        y_on;
  } seq_state_t;

  // gear to x goal
  function automatic logic [1:0] gear_x_goal(input logic [2:0] g);
    logic [1:0] r;
    case (g)
      3'd1, 3'd2: r = POS_LOW;
      3'd5, 3'd6: r = POS_HIGH;
      default:    r = POS_MIDDLE;
    endcase
    return r;
  endfunction

  // gear to y goal
  function automatic logic [1:0] gear_y_goal(input logic [2:0] g);
    logic [1:0] r;
    case (g)
      3'd1, 3'd3, 3'd5: r = POS_LOW;
      3'd2, 3'd4, 3'd6: r = POS_HIGH;
      default:          r = POS_MIDDLE;
    endcase
    return r;
  endfunction

endpackage

@@ src/tgss_step.sv @@
// ----------------------------------------------------------------------------
// tgss_step
// Next sequencer state and result for one tick or gear request.
// ----------------------------------------------------------------------------
module tgss_step (
  input  tgss_pkg::seq_state_t st,
  input  tgss_pkg::cfg_t       cfg,
  input  tgss_pkg::in_item_t   item,
  output tgss_pkg::seq_state_t st_next,
  output tgss_pkg::out_item_t  res
);

  // start the y move toward its goal
  function automatic tgss_pkg::seq_state_t start_y_move(input tgss_pkg::seq_state_t s);
    tgss_pkg::seq_state_t r;
    r            = s;
    r.wait_timer = '0;
    r.y_setpoint = s.goal_y;
    r.y_on       = 1'b1;
    r.phase_reg  = tgss_pkg::PH_Y_MOVE;
    return r;
  endfunction

  // begin an attempt, or give up when none are left
  function automatic tgss_pkg::seq_state_t start_attempt(input tgss_pkg::seq_state_t s);
    tgss_pkg::seq_state_t r;
    r = s;
    if (s.attempts_left == '0) begin
      r.phase_reg = tgss_pkg::PH_IDLE;
      r.x_on      = 1'b0;
      r.y_on      = 1'b0;
    end else begin
      r.y_on = 1'b0;
      if (s.selected_gear != tgss_pkg::GEAR_NEUTRAL) begin
        r.x_setpoint = s.goal_x;
        r.x_on       = 1'b1;
        r.wait_timer = '0;
        r.phase_reg  = tgss_pkg::PH_X_MOVE;
      end else begin
        r = start_y_move(r);
      end
    end
    return r;
  endfunction

  logic [15:0] timer_inc;
  logic        x_hit;
  logic        y_hit;
  logic        req_take;
  logic        is_idle;

  assign timer_inc = (st.wait_timer != tgss_pkg::TIMER_MAX) ? st.wait_timer + 16'd1
                                                             : st.wait_timer;
  assign x_hit   = (item.x_position == st.goal_x);
  assign y_hit   = (item.y_position == st.goal_y);
  assign is_idle = (st.phase_reg == tgss_pkg::PH_IDLE);

  // request filter: valid gear, idle or neutral, and a change of gear
  assign req_take = (item.gear <= tgss_pkg::GEAR_MAX)
                 && (is_idle || item.gear == tgss_pkg::GEAR_NEUTRAL)
                 && (item.gear != st.selected_gear);

  // next state
  always_comb begin
    st_next = st;
    if (item.kind) begin
      if (req_take) begin
        st_next.selected_gear = item.gear;
        if (item.gear != tgss_pkg::GEAR_NEUTRAL) begin
          st_next.goal_x = tgss_pkg::gear_x_goal(item.gear);
        end
        st_next.goal_y = tgss_pkg::gear_y_goal(item.gear);
        if (is_idle) begin
          st_next.phase_reg = tgss_pkg::PH_MOVE_CHECK;
        end
      end
    end else begin
      case (st.phase_reg)
        tgss_pkg::PH_INIT_CENTER: begin
          st_next.y_setpoint = tgss_pkg::POS_MIDDLE;
          st_next.y_on       = 1'b1;
          if (item.y_position == tgss_pkg::POS_MIDDLE) begin
            st_next.wait_timer = '0;
            st_next.phase_reg  = tgss_pkg::PH_INIT_SETTLE;
          end
        end
        tgss_pkg::PH_INIT_SETTLE: begin
          st_next.wait_timer = timer_inc;
          if (timer_inc >= cfg.long_settle_ticks) begin
            st_next.y_on      = 1'b0;
            st_next.phase_reg = tgss_pkg::PH_IDLE;
          end
        end
        tgss_pkg::PH_MOVE_CHECK: begin
          if (x_hit && y_hit) begin
            st_next.phase_reg = tgss_pkg::PH_IDLE;
          end else begin
            st_next.y_setpoint = tgss_pkg::POS_MIDDLE;
            st_next.y_on       = 1'b1;
            st_next.phase_reg  = tgss_pkg::PH_CENTER;
          end
        end
        tgss_pkg::PH_CENTER: begin
          if (item.y_position == tgss_pkg::POS_MIDDLE) begin
            st_next.wait_timer = '0;
            st_next.phase_reg  = tgss_pkg::PH_CENTER_SETTLE;
          end
        end
        tgss_pkg::PH_CENTER_SETTLE: begin
          st_next.wait_timer = timer_inc;
          if (timer_inc >= cfg.center_settle_ticks) begin
            st_next.attempts_left = cfg.attempt_limit;
            st_next = start_attempt(st_next);
          end
        end
        tgss_pkg::PH_X_MOVE: begin
          st_next.x_setpoint = st.goal_x;
          if (x_hit) begin
            st_next.wait_timer = '0;
            st_next.phase_reg  = tgss_pkg::PH_X_SETTLE;
          end else begin
            st_next.wait_timer = timer_inc;
            if (timer_inc >= cfg.x_timeout_ticks) begin
              st_next.x_setpoint = tgss_pkg::POS_MIDDLE;
              st_next.wait_timer = '0;
              st_next.phase_reg  = tgss_pkg::PH_X_RECOVER;
            end
          end
        end
        tgss_pkg::PH_X_RECOVER: begin
          st_next.wait_timer = timer_inc;
          if (timer_inc >= cfg.long_settle_ticks) begin
            st_next.x_on          = 1'b0;
            st_next.attempts_left = st.attempts_left - 3'd1;
            st_next = start_attempt(st_next);
          end
        end
        tgss_pkg::PH_X_SETTLE: begin
          st_next.wait_timer = timer_inc;
          if (timer_inc >= cfg.long_settle_ticks) begin
            st_next = start_y_move(st_next);
          end
        end
        tgss_pkg::PH_Y_MOVE: begin
          st_next.y_setpoint = st.goal_y;
          if (y_hit) begin
            st_next.wait_timer = '0;
            st_next.phase_reg  = tgss_pkg::PH_DONE_SETTLE;
          end else begin
            st_next.wait_timer = timer_inc;
            if (timer_inc >= cfg.y_timeout_ticks) begin
              st_next.y_setpoint = tgss_pkg::POS_MIDDLE;
              st_next.x_on       = 1'b0;
              st_next.wait_timer = '0;
              st_next.phase_reg  = tgss_pkg::PH_Y_RECOVER;
            end
          end
        end
        tgss_pkg::PH_Y_RECOVER: begin
          st_next.wait_timer = timer_inc;
          if (timer_inc >= cfg.long_settle_ticks) begin
            st_next.attempts_left = st.attempts_left - 3'd1;
            st_next = start_attempt(st_next);
          end
        end
        tgss_pkg::PH_DONE_SETTLE: begin
          st_next.wait_timer = timer_inc;
          if (timer_inc >= cfg.long_settle_ticks) begin
            st_next.x_on      = 1'b0;
            st_next.y_on      = 1'b0;
            st_next.phase_reg = tgss_pkg::PH_IDLE;
          end
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

  // result reflects the state after this transaction
  always_comb begin
    res.x_drive_target = st_next.x_setpoint;
    res.y_drive_target = st_next.y_setpoint;
    res.x_enable       = st_next.x_on;
    res.y_enable       = st_next.y_on;
    res.ready_res      = (st_next.phase_reg == tgss_pkg::PH_IDLE);
    res.current_gear   = st_next.selected_gear;
    res.phase          = st_next.phase_reg;
  end

endmodule

@@ src/two_axis_gear_shift_sequencer.sv @@
// ----------------------------------------------------------------------------
// two_axis_gear_shift_sequencer
// Tick-driven sequencer for a two-axis gear selector with retry on timeout.
// ----------------------------------------------------------------------------
// result: registered, and valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle while the result is drained; the state update is a single pass
//   through the step logic and the result register frees as it is read
// reset: synchronous; phase returns to init centering, config registers to
//   their defaults, and the result register empties
module two_axis_gear_shift_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tgss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tgss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  tgss_pkg::seq_state_t st;
  tgss_pkg::seq_state_t st_next;
  tgss_pkg::cfg_t       cfg;
  tgss_pkg::out_item_t  res;
  logic                 in_fire;

  // result register accepts whenever it is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  tgss_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_data),
    .st_next (st_next),
    .res     (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_timeout_ticks     <= 16'd1500;
      cfg.y_timeout_ticks     <= 16'd2000;
      cfg.long_settle_ticks   <= 16'd500;
      cfg.center_settle_ticks <= 16'd200;
      cfg.attempt_limit       <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        tgss_pkg::CFG_X_TIMEOUT:     cfg.x_timeout_ticks     <= cfg_data;
        tgss_pkg::CFG_Y_TIMEOUT:     cfg.y_timeout_ticks     <= cfg_data;
        tgss_pkg::CFG_LONG_SETTLE:   cfg.long_settle_ticks   <= cfg_data;
        tgss_pkg::CFG_CENTER_SETTLE: cfg.center_settle_ticks <= cfg_data;
        tgss_pkg::CFG_ATTEMPT_LIMIT: cfg.attempt_limit       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // sequencer state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase_reg     <= tgss_pkg::PH_INIT_CENTER;
      st.goal_x        <= tgss_pkg::POS_MIDDLE;
      st.goal_y        <= tgss_pkg::POS_MIDDLE;
      st.selected_gear <= tgss_pkg::GEAR_NEUTRAL;
      st.attempts_left <= '0;
      st.wait_timer    <= '0;
      st.x_setpoint    <= tgss_pkg::POS_MIDDLE;
      st.y_setpoint    <= tgss_pkg::POS_MIDDLE;
      st.x_on          <= 1'b0;
      st.y_on          <= 1'b0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

  // every accepted transaction leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  // state moves only on an accepted transaction
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(st))
    else $error("sequencer state changed without a transaction");

  // both drives are off whenever the sequencer sits idle
  a_idle_drives_off: assert property (@(posedge clk) disable iff (rst)
    (st.phase_reg == tgss_pkg::PH_IDLE) |-> (!st.x_on && !st.y_on))
    else $error("drive left enabled in idle");

  // a published result matches the state it was taken from
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (out_data.phase == st.phase_reg
                 && out_data.current_gear == st.selected_gear))
    else $error("result out of step with sequencer state");

endmodule
